@@ src/u2u_pkg.sv @@
// Shared types, constants and lead-byte decode for the UTF-8 to UTF-16 decoder.
package u2u_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned UNIT_W  = 16;
   localparam int unsigned POINT_W = 31;
   localparam int unsigned COUNT_W = 3;

   localparam logic [7:0] LEAD_TWO   = 8'hC0;
   localparam logic [7:0] LEAD_THREE = 8'hE0;
   localparam logic [7:0] LEAD_FOUR  = 8'hF0;
   localparam logic [7:0] LEAD_FIVE  = 8'hF8;
   localparam logic [7:0] LEAD_SIX   = 8'hFC;
   localparam logic [7:0] LEAD_NONE  = 8'hFE;

   localparam logic [5:0]  CONT_MASK    = 6'h3F;
   localparam logic [15:0] HIGH_SURR    = 16'hD800;
   localparam logic [15:0] LOW_SURR     = 16'hDC00;
   localparam logic [30:0] PLANE_OFFSET = 31'h0001_0000;

   // Payload mask of a lead byte, indexed by the sequence length.
   localparam logic [7:0] LEAD_MASK [8] = '{8'h00, 8'hFF, 8'h1F, 8'h0F,
                                            8'h07, 8'h03, 8'h01, 8'h00};

   typedef struct packed {
      logic                 emit;
      logic [POINT_W-1:0]   code_point;
      logic [POINT_W-1:0]   point_next;
      logic [COUNT_W-1:0]   expect_next;
   } dec_type;

   typedef struct packed {
      logic valid;
      logic pair;
      logic half;
   } out_status_type;

   // Sequence length announced by a lead byte. Continuation-range bytes and
   // the two bytes above the six-byte range stand alone.
   function automatic logic [COUNT_W-1:0] lead_length(input logic [BYTE_W-1:0] b);
      logic [COUNT_W-1:0] len;
      if (b < LEAD_TWO || b >= LEAD_NONE) begin
         len = 3'd1;
      end else if (b < LEAD_THREE) begin
         len = 3'd2;
      end else if (b < LEAD_FOUR) begin
         len = 3'd3;
      end else if (b < LEAD_FIVE) begin
         len = 3'd4;
      end else if (b < LEAD_SIX) begin
         len = 3'd5;
      end else begin
         len = 3'd6;
      end
      return len;
   endfunction

endpackage

@@ src/utf8_to_utf16_decoder.sv @@
// Top level of the UTF-8 to UTF-16 decoder: input register, sequence state and result stage.
//
// Input words arrive on req_* one byte at a time; req_tlast marks the final byte of
// a text and flushes any open sequence. Result words leave on rsp_*: rsp_tdata is
// a UTF-16 unit, rsp_tuser marks the final unit caused by one byte and rsp_tlast
// the final unit of the whole text. A byte that leaves a sequence open gives no
// word; a completed value below 0x10000 gives one word, a larger one a surrogate
// pair on two consecutive words.
// An accepted byte sits in the input register, where the decoder folds it into the
// sequence state; its words pass through the result register onto rsp_*.
// One byte is accepted per cycle while the result register can take its words.
// The result register is the limit: a surrogate pair holds it for two output
// words. Bytes that complete nothing pass even while a word waits. When
// rsp_tready is low the result word holds, and req_tready drops once the byte
// in the input register completes a value. Synchronous reset empties both
// stages and clears the sequence state; no text is in progress afterward.
module utf8_to_utf16_decoder (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [u2u_pkg::BYTE_W-1:0]  req_tdata,   // byte_in [7:0]
   input  logic                        req_tlast,   // last_byte
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [u2u_pkg::UNIT_W-1:0]  rsp_tdata,   // code_unit [15:0]
   output logic                        rsp_tuser,   // last_of_run
   output logic                        rsp_tlast    // end_of_text
);

   logic                        in_valid_ff, in_valid_in;
   logic [u2u_pkg::BYTE_W-1:0]  in_byte_ff;
   logic                        in_last_ff;
   logic [u2u_pkg::POINT_W-1:0] point_ff, point_in;
   logic [u2u_pkg::COUNT_W-1:0] expect_ff, expect_in;
   logic                        advance;
   logic                        out_free;
   u2u_pkg::dec_type            dec;
   u2u_pkg::out_status_type     out_status;

   u2u_decode u_decode (
      .byte_in      (in_byte_ff),
      .last_byte    (in_last_ff),
      .point        (point_ff),
      .expect_count (expect_ff),
      .dec          (dec)
   );

   // A byte that completes nothing never waits on the result stage.
   assign advance    = in_valid_ff && (!dec.emit || out_free);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      point_in    = point_ff;
      expect_in   = expect_ff;
      if (advance) begin
         in_valid_in = 1'b0;
         point_in    = dec.point_next;
         expect_in   = dec.expect_next;
      end
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         point_ff    <= '0;
         expect_ff   <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         point_ff    <= point_in;
         expect_ff   <= expect_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   u2u_unit_out u_unit_out (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && dec.emit),
      .code_point (dec.code_point),
      .fin        (in_last_ff),
      .free       (out_free),
      .status     (out_status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef ASSERT_OFF
   a_half_in_pair: assert property (@(posedge clock) disable iff (reset)
      out_status.half |-> (out_status.pair && out_status.valid))
      else $error("second surrogate half outside a pair");

   a_emit_closes: assert property (@(posedge clock) disable iff (reset)
      (advance && dec.emit) |=> (expect_ff == '0 && point_ff == '0))
      else $error("sequence state not cleared after a completed value");

   a_expect_range: assert property (@(posedge clock) disable iff (reset)
      expect_ff <= 3'd5)
      else $error("more continuation bytes expected than a lead byte allows");

   a_end_is_run_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> rsp_tuser)
      else $error("end of text on a word that does not end its run");
`endif

endmodule

@@ src/u2u_decode.sv @@
// Byte decoder: folds one UTF-8 byte into the open sequence and flags completion.
module u2u_decode (
   input  logic [u2u_pkg::BYTE_W-1:0]  byte_in,
   input  logic                        last_byte,
   input  logic [u2u_pkg::POINT_W-1:0] point,
   input  logic [u2u_pkg::COUNT_W-1:0] expect_count,
   output u2u_pkg::dec_type            dec
);

   logic [u2u_pkg::COUNT_W-1:0] lead_len;
   logic [u2u_pkg::POINT_W-1:0] point_acc;
   logic [u2u_pkg::COUNT_W-1:0] expect_acc;

   always_comb begin
      lead_len = u2u_pkg::lead_length(byte_in);
      if (expect_count == '0) begin
         point_acc  = {{(u2u_pkg::POINT_W-u2u_pkg::BYTE_W){1'b0}},
                       byte_in & u2u_pkg::LEAD_MASK[lead_len]};
         expect_acc = lead_len - 3'd1;
      end else begin
         // The top bits of a continuation byte are ignored, valid or not.
         point_acc  = {point[u2u_pkg::POINT_W-7:0], byte_in[5:0] & u2u_pkg::CONT_MASK};
         expect_acc = expect_count - 3'd1;
      end

      dec.emit       = (expect_acc == '0) || last_byte;
      dec.code_point = point_acc;
      if (dec.emit) begin
         dec.point_next  = '0;
         dec.expect_next = '0;
      end else begin
         dec.point_next  = point_acc;
         dec.expect_next = expect_acc;
      end
   end

endmodule

@@ src/u2u_unit_out.sv @@
// Result register: holds one code point and sends it as one unit or a surrogate pair.
module u2u_unit_out (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic [u2u_pkg::POINT_W-1:0]   code_point,
   input  logic                          fin,
   output logic                          free,
   output u2u_pkg::out_status_type       status,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [u2u_pkg::UNIT_W-1:0]    rsp_tdata,  // code_unit [15:0]
   output logic                          rsp_tuser,  // last_of_run
   output logic                          rsp_tlast   // end_of_text
);

   logic                        valid_ff, valid_in;
   logic                        half_ff, half_in;
   logic                        pair_ff;
   logic                        fin_ff;
   logic [u2u_pkg::POINT_W-1:0] value_ff;
   logic [u2u_pkg::POINT_W-1:0] offset_value;
   logic                        final_unit;
   logic                        pop_final;

   assign final_unit = !pair_ff || half_ff;
   assign pop_final  = valid_ff && rsp_tready && final_unit;
   assign free       = !valid_ff || pop_final;

   always_comb begin
      valid_in = valid_ff;
      half_in  = half_ff;
      if (load) begin
         valid_in = 1'b1;
         half_in  = 1'b0;
      end else if (pop_final) begin
         valid_in = 1'b0;
         half_in  = 1'b0;
      end else if (valid_ff && rsp_tready) begin
         half_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         half_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         half_ff  <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         value_ff <= code_point;
         fin_ff   <= fin;
         pair_ff  <= |code_point[u2u_pkg::POINT_W-1:16];
      end
   end

   // Each surrogate half keeps only ten bits of the offset value.
   always_comb begin
      offset_value = value_ff - u2u_pkg::PLANE_OFFSET;
      if (!pair_ff) begin
         rsp_tdata = value_ff[u2u_pkg::UNIT_W-1:0];
      end else if (!half_ff) begin
         rsp_tdata = u2u_pkg::HIGH_SURR + {6'd0, offset_value[19:10]};
      end else begin
         rsp_tdata = u2u_pkg::LOW_SURR + {6'd0, offset_value[9:0]};
      end
   end

   assign rsp_tvalid   = valid_ff;
   assign rsp_tuser    = final_unit;
   assign rsp_tlast    = final_unit && fin_ff;
   assign status.valid = valid_ff;
   assign status.pair  = pair_ff;
   assign status.half  = half_ff;

endmodule

@@ dv/u2u_checker.sv @@
// Checker for the UTF-8 to UTF-16 decoder: watches both channels, predicts and compares words.
`timescale 1ns / 100ps

module u2u_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [u2u_pkg::BYTE_W-1:0] req_tdata,    // byte_in [7:0]
   input  logic                       req_tlast,    // last_byte
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [u2u_pkg::UNIT_W-1:0] rsp_tdata,    // code_unit [15:0]
   input  logic                       rsp_tuser,    // last_of_run
   input  logic                       rsp_tlast,    // end_of_text
   output int                         fail_count,
   output int                         words_waiting,
   output int                         words_checked,
   output int                         pairs_predicted
);

   typedef struct packed {
      logic [u2u_pkg::UNIT_W-1:0] unit;
      logic                       run_end;
      logic                       text_end;
   } unit_word_type;

   unit_word_type               expected_units [$];
   unit_word_type               oldest;
   logic [u2u_pkg::POINT_W-1:0] point_acc;
   logic [u2u_pkg::COUNT_W-1:0] cont_left;

   task automatic report(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      fail_count++;
   endtask

   // Folds one accepted byte into the sequence state and queues the units it completes.
   task automatic decode_byte(input logic [u2u_pkg::BYTE_W-1:0] b, input logic fin);
      logic [u2u_pkg::COUNT_W-1:0] span;
      logic [7:0]                  keep;
      logic [u2u_pkg::POINT_W-1:0] value;
      logic [u2u_pkg::POINT_W-1:0] offset;
      if (cont_left == '0) begin
         if (b < u2u_pkg::LEAD_TWO || b >= u2u_pkg::LEAD_NONE) begin
            span = 3'd1;
            keep = 8'hFF;
         end else if (b < u2u_pkg::LEAD_THREE) begin
            span = 3'd2;
            keep = 8'h1F;
         end else if (b < u2u_pkg::LEAD_FOUR) begin
            span = 3'd3;
            keep = 8'h0F;
         end else if (b < u2u_pkg::LEAD_FIVE) begin
            span = 3'd4;
            keep = 8'h07;
         end else if (b < u2u_pkg::LEAD_SIX) begin
            span = 3'd5;
            keep = 8'h03;
         end else begin
            span = 3'd6;
            keep = 8'h01;
         end
         point_acc = u2u_pkg::POINT_W'(b & keep);
         cont_left = span - 3'd1;
      end else begin
         // The top two bits of a continuation byte are dropped unchecked.
         point_acc = {point_acc[u2u_pkg::POINT_W-7:0], b[5:0] & u2u_pkg::CONT_MASK};
         cont_left = cont_left - 3'd1;
      end
      if (cont_left != '0 && !fin) begin
         return;
      end
      value     = point_acc;
      point_acc = '0;
      cont_left = '0;
      if (value < u2u_pkg::PLANE_OFFSET) begin
         expected_units.push_back('{value[u2u_pkg::UNIT_W-1:0], 1'b1, fin});
      end else begin
         offset = value - u2u_pkg::PLANE_OFFSET;
         expected_units.push_back('{u2u_pkg::HIGH_SURR + u2u_pkg::UNIT_W'(offset[19:10]),
                                    1'b0, 1'b0});
         expected_units.push_back('{u2u_pkg::LOW_SURR + u2u_pkg::UNIT_W'(offset[9:0]),
                                    1'b1, fin});
         pairs_predicted++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_units.delete();
         point_acc = '0;
         cont_left = '0;
      end else begin
         if (req_tvalid && req_tready) begin
            decode_byte(req_tdata, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_units.size() == 0) begin
               report($sformatf("word %h arrived with nothing expected", rsp_tdata));
            end else begin
               oldest = expected_units.pop_front();
               words_checked++;
               if (rsp_tdata !== oldest.unit) begin
                  report($sformatf("code unit %h, expected %h", rsp_tdata, oldest.unit));
               end
               if (rsp_tuser !== oldest.run_end) begin
                  report($sformatf("last_of_run %b, expected %b on unit %h",
                                   rsp_tuser, oldest.run_end, oldest.unit));
               end
               if (rsp_tlast !== oldest.text_end) begin
                  report($sformatf("end_of_text %b, expected %b on unit %h",
                                   rsp_tlast, oldest.text_end, oldest.unit));
               end
            end
         end
      end
      words_waiting = expected_units.size();
   end

endmodule

@@ dv/tb_top.sv @@
// Testbench top for the UTF-8 to UTF-16 decoder: clock, reset, byte stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;

   localparam int unsigned RANDOM_BYTES   = 1800;
   localparam int unsigned CALM_AFTER     = 1550;
   localparam int unsigned CYCLE_LIMIT    = 500000;
   localparam int unsigned DIRECTED_COUNT = 23;

   // Bit 8 carries the end-of-text flag, bits 7:0 the byte.
   localparam logic [8:0] DIRECTED [DIRECTED_COUNT] = '{
      9'h000, 9'h07F, 9'h080, 9'h0BF, 9'h0FF,
      9'h0C2, 9'h0A9,
      9'h0E2, 9'h082, 9'h041,
      9'h0F0, 9'h09F, 9'h098, 9'h080,
      9'h0FD, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF,
      9'h0F4, 9'h18F,
      9'h1FE
   };

   logic                       clock;
   logic                       reset;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [u2u_pkg::BYTE_W-1:0] req_tdata;
   logic                       req_tlast;
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic [u2u_pkg::UNIT_W-1:0] rsp_tdata;
   logic                       rsp_tuser;
   logic                       rsp_tlast;

   int          fail_count;
   int          words_waiting;
   int          words_checked;
   int          pairs_predicted;
   int unsigned bytes_sent;
   int unsigned texts_sent;
   int unsigned cycle_count;
   int unsigned gap_odds;
   bit          calm;

   utf8_to_utf16_decoder u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   u2u_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .fail_count      (fail_count),
      .words_waiting   (words_waiting),
      .words_checked   (words_checked),
      .pairs_predicted (pairs_predicted)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d words outstanding",
                  cycle_count, words_waiting);
         $display("Verification failed");
         $finish;
      end
   end

   // Result-side back-pressure: stretches of heavy, light or no stalling.
   initial begin
      int unsigned stretch;
      int unsigned odds;
      rsp_tready = 1'b1;
      @(posedge clock);
      forever begin
         stretch = $urandom_range(20, 200);
         odds    = $urandom_range(0, 2) * 4;
         repeat (stretch) begin
            @(posedge clock);
            if (!calm && odds != 0 && $urandom_range(1, odds) == 1) begin
               rsp_tready <= 1'b0;
               repeat ($urandom_range(1, 15)) @(posedge clock);
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   // Offers one word and returns at the edge that accepts it.
   task automatic push_byte(input logic [u2u_pkg::BYTE_W-1:0] b, input logic fin);
      if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_tvalid <= 1'b0;
         req_tdata  <= u2u_pkg::BYTE_W'($urandom);
         req_tlast  <= 1'($urandom);
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      if (fin) begin
         texts_sent++;
      end
   endtask

   // Mostly well-formed sequences with random payload; some noise, cut-off
   // sequences and bad continuation bytes.
   task automatic random_sequence();
      int unsigned kind;
      int unsigned pick;
      int unsigned span;
      int unsigned cut;
      logic [7:0]  lead;
      logic [7:0]  b;
      bit          end_text;
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
         push_byte(8'($urandom), $urandom_range(0, 15) == 0);
         return;
      end
      pick = $urandom_range(0, 99);
      span = pick < 30 ? 1 : pick < 50 ? 2 : pick < 65 ? 3 : pick < 80 ? 4 : pick < 90 ? 5 : 6;
      case (span)
         1: begin
            if ($urandom_range(0, 9) == 0) begin
               pick = $urandom_range(0, 65);
               lead = pick < 64 ? 8'h80 + 8'(pick) : (pick == 64 ? 8'hFE : 8'hFF);
            end else begin
               lead = 8'($urandom_range(0, 127));
            end
         end
         2: lead = u2u_pkg::LEAD_TWO + 8'($urandom_range(0, 31));
         3: lead = u2u_pkg::LEAD_THREE + 8'($urandom_range(0, 15));
         4: lead = u2u_pkg::LEAD_FOUR + 8'($urandom_range(0, 7));
         5: lead = u2u_pkg::LEAD_FIVE + 8'($urandom_range(0, 3));
         default: lead = u2u_pkg::LEAD_SIX + 8'($urandom_range(0, 1));
      endcase
      cut      = kind < 16 ? $urandom_range(1, span) : span;
      end_text = $urandom_range(0, 11) == 0;
      for (int k = 1; k <= cut; k++) begin
         if (k == 1) begin
            b = lead;
         end else if (kind < 24 && $urandom_range(0, 3) == 0) begin
            b = 8'($urandom);
         end else begin
            b = {2'b10, 6'($urandom)};
         end
         push_byte(b, k == cut && (cut < span || end_text));
      end
   endtask

   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      calm        = 1'b0;
      gap_odds    = 4;
      cycle_count = 0;
      bytes_sent  = 0;
      texts_sent  = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int k = 0; k < DIRECTED_COUNT; k++) begin
         push_byte(DIRECTED[k][7:0], DIRECTED[k][8]);
      end

      while (bytes_sent < DIRECTED_COUNT + RANDOM_BYTES) begin
         if ($urandom_range(0, 19) == 0) begin
            gap_odds = $urandom_range(0, 2) * 3;
         end
         calm = bytes_sent > DIRECTED_COUNT + CALM_AFTER;
         random_sequence();
      end
      // Close whatever sequence is still open.
      push_byte(8'h41, 1'b1);
      req_tvalid <= 1'b0;

      repeat (4) @(posedge clock);
      while (words_waiting != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d bytes in %0d texts, checked %0d result words (%0d surrogate pairs).",
               bytes_sent, texts_sent, words_checked, pairs_predicted);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches found", fail_count);
         $display("Verification failed");
      end
      $finish;
   end

endmodule
